@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL; taylor_series_sine.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never occurs outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ hw/rtl/tss_pkg.sv @@
// Package: constants, types and microcode table of the Taylor-series sine block.
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

    // Formats
    localparam int FRAC_BITS   = 40;
    localparam int MAX_TERMS   = 32;
    localparam int ACC_FRAC    = 48;
    localparam int OUT_SH      = ACC_FRAC - FRAC_BITS;
    localparam int W_ANGLE     = FRAC_BITS + 3;
    localparam int W_SINE      = FRAC_BITS + 2;
    localparam int W_LIMIT     = 21;
    localparam int LIMIT_RESET = 110;

    // Datapath widths
    localparam int W_X      = ACC_FRAC + 3;
    localparam int W_HALF   = 28;
    localparam int W_OP     = 2 * W_HALF;
    localparam int W_PP     = 2 * W_HALF;
    localparam int W_PROD   = 2 * W_OP;
    localparam int W_DIVD   = W_PROD - ACC_FRAC;
    localparam int DIV_BITS = 8;
    localparam int DIV_STEPS = W_DIVD / DIV_BITS;
    localparam int W_DCNT   = $clog2(DIV_STEPS);
    localparam int W_SUM    = 58;
    localparam int W_OMAG   = W_SUM - OUT_SH;
    localparam int W_CNT    = $clog2(MAX_TERMS + 1);
    localparam int W_I      = $clog2(2 * MAX_TERMS + 2);
    localparam int W_D      = $clog2(2 * MAX_TERMS * (2 * MAX_TERMS + 1) + 1);
    localparam int W_STEP   = 5;

    // 2*pi in Q.48
    localparam logic [W_X-1:0]    TWO_PI    = W_X'(64'd1768559438012856);
    localparam logic [W_PROD-1:0] MUL_HALF  = W_PROD'(1) << (ACC_FRAC - 1);
    localparam logic [W_SUM-1:0]  OUT_HALF  = W_SUM'((2 ** OUT_SH) / 2);
    localparam logic [W_OMAG-1:0] ONE_MAG   = W_OMAG'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQUARE,
        OP_TERM,
        OP_DIVLOAD,
        OP_DIV,
        OP_NEXT,
        OP_ROUND,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_STOP,
        C_DIV_BUSY,
        C_OUT_BUSY
    } t_cond;

    typedef enum logic {
        SRC_SQUARE,
        SRC_TERM
    } t_src;

    typedef struct packed {
        t_op               op;
        logic              mul_en;
        logic [1:0]        mul_k;
        t_src              mul_src;
        logic              acc_en;
        logic              acc_clr;
        t_cond             cond;
        logic [W_STEP-1:0] target;
    } t_uword;

    // Program addresses
    localparam logic [W_STEP-1:0] P_SQ_PP0  = W_STEP'(0);
    localparam logic [W_STEP-1:0] P_SQ_PP1  = W_STEP'(1);
    localparam logic [W_STEP-1:0] P_SQ_PP2  = W_STEP'(2);
    localparam logic [W_STEP-1:0] P_SQ_PP3  = W_STEP'(3);
    localparam logic [W_STEP-1:0] P_SQ_ACC  = W_STEP'(4);
    localparam logic [W_STEP-1:0] P_SQUARE  = W_STEP'(5);
    localparam logic [W_STEP-1:0] P_TERM    = W_STEP'(6);
    localparam logic [W_STEP-1:0] P_TM_PP0  = W_STEP'(7);
    localparam logic [W_STEP-1:0] P_TM_PP1  = W_STEP'(8);
    localparam logic [W_STEP-1:0] P_TM_PP2  = W_STEP'(9);
    localparam logic [W_STEP-1:0] P_TM_PP3  = W_STEP'(10);
    localparam logic [W_STEP-1:0] P_TM_ACC  = W_STEP'(11);
    localparam logic [W_STEP-1:0] P_DIVLOAD = W_STEP'(12);
    localparam logic [W_STEP-1:0] P_DIV     = W_STEP'(13);
    localparam logic [W_STEP-1:0] P_NEXT    = W_STEP'(14);
    localparam logic [W_STEP-1:0] P_ROUND   = W_STEP'(15);
    localparam logic [W_STEP-1:0] P_EMIT    = W_STEP'(16);
    localparam logic [W_STEP-1:0] P_IDLE    = W_STEP'(17);
    localparam logic [W_STEP-1:0] P_LAST    = P_IDLE;

    // Divisor i*(i+1) for the term that follows term number cnt, i = 2*cnt+2
    function automatic logic [W_D-1:0] div_of(input logic [W_CNT-1:0] cnt);
        logic [W_I-1:0] i;
        logic [W_D-1:0] d;
        i = W_I'({cnt, 1'b0}) + W_I'(2);
        d = W_D'(i) * W_D'(i + W_I'(1));
        return d;
    endfunction

    function automatic t_uword mk(input t_op op, input logic mul_en, input logic [1:0] mul_k,
                                  input t_src src, input logic acc_en, input logic acc_clr,
                                  input t_cond cond, input logic [W_STEP-1:0] target);
        t_uword w;
        w.op      = op;
        w.mul_en  = mul_en;
        w.mul_k   = mul_k;
        w.mul_src = src;
        w.acc_en  = acc_en;
        w.acc_clr = acc_clr;
        w.cond    = cond;
        w.target  = target;
        return w;
    endfunction

    // Microcode ROM
    function automatic t_uword uprog(input logic [W_STEP-1:0] step);
        t_uword w;
        case (step)
            P_SQ_PP0:  w = mk(OP_NONE,    1'b1, 2'd0, SRC_SQUARE, 1'b0, 1'b1, C_NEXT, '0);
            P_SQ_PP1:  w = mk(OP_NONE,    1'b1, 2'd1, SRC_SQUARE, 1'b1, 1'b0, C_NEXT, '0);
            P_SQ_PP2:  w = mk(OP_NONE,    1'b1, 2'd2, SRC_SQUARE, 1'b1, 1'b0, C_NEXT, '0);
            P_SQ_PP3:  w = mk(OP_NONE,    1'b1, 2'd3, SRC_SQUARE, 1'b1, 1'b0, C_NEXT, '0);
            P_SQ_ACC:  w = mk(OP_NONE,    1'b0, 2'd0, SRC_SQUARE, 1'b1, 1'b0, C_NEXT, '0);
            P_SQUARE:  w = mk(OP_SQUARE,  1'b0, 2'd0, SRC_SQUARE, 1'b0, 1'b0, C_NEXT, '0);
            P_TERM:    w = mk(OP_TERM,    1'b0, 2'd0, SRC_TERM,   1'b0, 1'b0, C_STOP, P_ROUND);
            P_TM_PP0:  w = mk(OP_NONE,    1'b1, 2'd0, SRC_TERM,   1'b0, 1'b1, C_NEXT, '0);
            P_TM_PP1:  w = mk(OP_NONE,    1'b1, 2'd1, SRC_TERM,   1'b1, 1'b0, C_NEXT, '0);
            P_TM_PP2:  w = mk(OP_NONE,    1'b1, 2'd2, SRC_TERM,   1'b1, 1'b0, C_NEXT, '0);
            P_TM_PP3:  w = mk(OP_NONE,    1'b1, 2'd3, SRC_TERM,   1'b1, 1'b0, C_NEXT, '0);
            P_TM_ACC:  w = mk(OP_NONE,    1'b0, 2'd0, SRC_TERM,   1'b1, 1'b0, C_NEXT, '0);
            P_DIVLOAD: w = mk(OP_DIVLOAD, 1'b0, 2'd0, SRC_TERM,   1'b0, 1'b0, C_NEXT, '0);
            P_DIV:     w = mk(OP_DIV,     1'b0, 2'd0, SRC_TERM,   1'b0, 1'b0, C_DIV_BUSY, P_DIV);
            P_NEXT:    w = mk(OP_NEXT,    1'b0, 2'd0, SRC_TERM,   1'b0, 1'b0, C_ALWAYS, P_TERM);
            P_ROUND:   w = mk(OP_ROUND,   1'b0, 2'd0, SRC_TERM,   1'b0, 1'b0, C_NEXT, '0);
            P_EMIT:    w = mk(OP_EMIT,    1'b0, 2'd0, SRC_TERM,   1'b0, 1'b0, C_OUT_BUSY, P_EMIT);
            P_IDLE:    w = mk(OP_LOAD,    1'b0, 2'd0, SRC_SQUARE, 1'b0, 1'b0, C_NO_ACCEPT, P_IDLE);
            default:   w = mk(OP_NONE,    1'b0, 2'd0, SRC_SQUARE, 1'b0, 1'b0, C_ALWAYS, P_IDLE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/taylor_series_sine.sv @@
// Top level: microcoded Taylor-series sine of an unsigned Q3.40 angle.
// The block takes one angle word (Q3.40 radians), folds it once by 2*pi when it lies
// above 2*pi, and sums the alternating series x - x^3/3! + x^5/5!, term by term, in Q10.48 until a term drops below
// term_limit (Q.40 units) or 32 terms have been added; it returns the sum rounded to
// Q1.40 and saturated to +-1.0, with term_cap_hit set when the term count ended the sum.
// A small program in a ROM drives one 28x28 multiplier (a 56x56 product takes four
// partial products) and a divider by i*(i+1) that retires 8 quotient bits a cycle.
// One word is worked on at a time: the result word is written in the emit step, and the
// next angle is taken in the idle step that the emit step leads to. Each term passes the
// term step, the partial-product and accumulate steps on the multiplier, the divider load,
// the divider steps and the next-term step. The result sits in an output register, so the
// next angle word is taken while a result still waits; a further result holds in the emit
// step until the waiting one is taken. term_limit is to be written by the user through
// i_cfg_wr_en/i_cfg_wr_data only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module taylor_series_sine import tss_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [W_LIMIT-1:0]       i_cfg_wr_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [W_ANGLE-1:0]       i_angle,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [W_SINE-1:0] o_sine,
    output logic                     o_term_cap_hit
);

    // Sequencer and control registers
    logic [W_STEP-1:0]  r_step, n_step;
    logic [W_LIMIT-1:0] r_limit;
    logic [W_CNT-1:0]   r_cnt;
    logic [W_DCNT-1:0]  r_dcnt;
    logic               r_out_valid;

    // Datapath registers
    logic [W_X-1:0]     r_x;
    logic [W_OP-1:0]    r_x2;
    logic [W_OP-1:0]    r_mag;
    logic [W_SUM-1:0]   r_sum;
    logic               r_neg;
    logic               r_cap;
    logic [W_PP-1:0]    r_pp;
    logic [1:0]         r_pp_sh;
    logic [W_PROD-1:0]  r_prod;
    logic [W_D-1:0]     r_d;
    logic [W_D-1:0]     r_rem;
    logic [W_DIVD-1:0]  r_dq;
    logic [W_OMAG-1:0]  r_omag;
    logic               r_oneg;
    logic [W_SINE-1:0]  r_sine;
    logic               r_cap_out;

    t_uword             uw;
    logic               in_accept;
    logic               out_busy;
    logic               mag_low;
    logic               stop;
    logic               taken;
    logic [W_X-1:0]     x_in;
    logic [W_X-1:0]     x_red;
    logic [W_OP-1:0]    op_a;
    logic [W_OP-1:0]    op_b;
    logic [W_HALF-1:0]  a_half;
    logic [W_HALF-1:0]  b_half;
    logic [W_PROD-1:0]  pp_aligned;
    logic [W_D-1:0]     d_cur;
    logic [W_PROD-1:0]  rnd_const;
    logic [W_PROD-1:0]  prod_rnd;
    logic [W_SUM-1:0]   mag_ext;
    logic               sum_neg;
    logic [W_SUM-1:0]   sum_rnd;
    logic [W_OMAG-1:0]  omag_sat;
    logic [W_SINE-1:0]  sine_mag;
    logic [W_D-1:0]     div_rem;
    logic [W_DIVD-1:0]  div_dq;
    logic [W_D:0]       div_t;

    // Fetch the control word of the current step
    assign uw = uprog(r_step);

    assign o_in_stall  = (r_step != P_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_busy    = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_sine      = signed'(r_sine);
    assign o_term_cap_hit = r_cap_out;

    // Fold the angle once by 2*pi
    assign x_in  = W_X'(i_angle) << OUT_SH;
    assign x_red = (x_in > TWO_PI) ? (x_in - TWO_PI) : x_in;

    // Stop on a small term or on the term cap
    assign mag_low = r_mag < (W_OP'(r_limit) << OUT_SH);
    assign stop    = mag_low || (r_cnt == W_CNT'(MAX_TERMS));

    // Multiplier operands: x*x for the square, term*x^2 for each new term
    assign op_a   = (uw.mul_src == SRC_SQUARE) ? W_OP'(r_x) : r_mag;
    assign op_b   = (uw.mul_src == SRC_SQUARE) ? W_OP'(r_x) : r_x2;
    assign a_half = uw.mul_k[1] ? op_a[W_OP-1:W_HALF] : op_a[W_HALF-1:0];
    assign b_half = uw.mul_k[0] ? op_b[W_OP-1:W_HALF] : op_b[W_HALF-1:0];
    assign pp_aligned = W_PROD'(r_pp) << (W_HALF * r_pp_sh);

    // Round the product to Q.48; fold in i*(i+1)/2 so the divide rounds to nearest
    assign d_cur     = div_of(r_cnt);
    assign rnd_const = MUL_HALF |
                       ((uw.op == OP_DIVLOAD) ? (W_PROD'(d_cur >> 1) << ACC_FRAC) : '0);
    assign prod_rnd  = r_prod + rnd_const;

    assign mag_ext = W_SUM'(r_mag);

    // Output rounding: |sum| + half in one add
    assign sum_neg  = r_sum[W_SUM-1];
    assign sum_rnd  = sum_neg ? (~r_sum + OUT_HALF + W_SUM'(1)) : (r_sum + OUT_HALF);
    assign omag_sat = (r_omag > ONE_MAG) ? ONE_MAG : r_omag;
    assign sine_mag = W_SINE'(omag_sat);

    // Divider: retire DIV_BITS quotient bits a cycle; remainder stays below i*(i+1)
    always_comb begin
        div_rem = r_rem;
        div_dq  = r_dq;
        div_t   = '0;
        for (int j = 0; j < DIV_BITS; j++) begin
            div_t  = {div_rem, div_dq[W_DIVD-1]};
            div_dq = {div_dq[W_DIVD-2:0], 1'b0};
            if (div_t >= {1'b0, r_d}) begin
                div_rem   = W_D'(div_t - {1'b0, r_d});
                div_dq[0] = 1'b1;
            end else begin
                div_rem = W_D'(div_t);
            end
        end
    end

    // Sequencer: jump on the control word's condition, else advance; the idle step advances to the first square step
    always_comb begin
        case (uw.cond)
            C_NEXT:      taken = 1'b0;
            C_ALWAYS:    taken = 1'b1;
            C_NO_ACCEPT: taken = !in_accept;
            C_STOP:      taken = stop;
            C_DIV_BUSY:  taken = (r_dcnt != W_DCNT'(DIV_STEPS - 1));
            C_OUT_BUSY:  taken = out_busy;
            default:     taken = 1'b1;
        endcase
        if (taken) begin
            n_step = uw.target;
        end else if (r_step == P_LAST) begin
            n_step = P_SQ_PP0;
        end else begin
            n_step = r_step + W_STEP'(1);
        end
    end

    // Control state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= P_IDLE;
            r_limit     <= W_LIMIT'(LIMIT_RESET);
            r_cnt       <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            // Count added terms
            if (uw.op == OP_LOAD && in_accept) begin
                r_cnt <= '0;
            end else if (uw.op == OP_NEXT) begin
                r_cnt <= r_cnt + W_CNT'(1);
            end
            // Count divider cycles; cleared at each divider load and wrapped back to zero after the last one
            if (uw.op == OP_DIVLOAD) begin
                r_dcnt <= '0;
            end else if (uw.op == OP_DIV) begin
                r_dcnt <= r_dcnt + W_DCNT'(1);
            end
            // Hold the result word until taken
            if (uw.op == OP_EMIT && !out_busy) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (uw.mul_en) begin
            r_pp    <= W_PP'(a_half) * W_PP'(b_half);
            r_pp_sh <= 2'(uw.mul_k[1]) + 2'(uw.mul_k[0]);
        end
        if (uw.acc_clr) begin
            r_prod <= '0;
        end else if (uw.acc_en) begin
            r_prod <= r_prod + pp_aligned;
        end
        case (uw.op)
            OP_LOAD: begin
                if (in_accept) begin
                    r_x   <= x_red;
                    r_sum <= '0;
                    r_neg <= 1'b0;
                end
            end
            OP_SQUARE: begin
                r_x2  <= prod_rnd[ACC_FRAC +: W_OP];
                r_mag <= W_OP'(r_x);
            end
            OP_TERM: begin
                // A stop with the term still large means the cap ended the sum
                r_cap <= !mag_low;
                if (!stop) begin
                    r_sum <= r_neg ? (r_sum - mag_ext) : (r_sum + mag_ext);
                    r_neg <= !r_neg;
                end
            end
            OP_DIVLOAD: begin
                r_d   <= d_cur;
                r_rem <= '0;
                r_dq  <= prod_rnd[W_PROD-1:ACC_FRAC];
            end
            OP_DIV: begin
                r_rem <= div_rem;
                r_dq  <= div_dq;
            end
            OP_NEXT: begin
                r_mag <= r_dq[W_OP-1:0];
            end
            OP_ROUND: begin
                r_omag <= sum_rnd[W_SUM-1:OUT_SH];
                r_oneg <= sum_neg;
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    r_sine    <= r_oneg ? (W_SINE'(0) - sine_mag) : sine_mag;
                    r_cap_out <= r_cap;
                end
            end
            default: ;
        endcase
    end

    // Assertions
    `ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt > W_CNT'(MAX_TERMS), "term count past cap")
    `ASSERT_HOLDS(a_dcnt_idle, i_clk, i_rst_n, (r_step != P_DIV) |-> (r_dcnt == '0), "divider count left nonzero")
    `ASSERT_HOLDS(a_out_from_emit, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_step) == P_EMIT), "result word without emit step")
    `ASSERT_HOLDS(a_cap_count, i_clk, i_rst_n, (r_step == P_ROUND && r_cap) |-> (r_cnt == W_CNT'(MAX_TERMS)), "cap flag below term cap")

endmodule

`default_nettype wire
